FILE: hdl/ttlp_pkg.sv
// Shared types and constants for the text-then-length-prefixed deframer.
// Depends on nothing; imported by text_then_length_prefixed_deframer.
package ttlp_pkg;

    localparam logic [7:0]  CR_BYTE           = 8'h0D;
    localparam logic [7:0]  LF_BYTE           = 8'h0A;
    localparam logic [4:0]  SWITCH_LINE_LEN   = 5'd17;   // prefix (10 + 1) plus 6 more bytes
    localparam logic [4:0]  PREFIX_LEN        = 5'd11;
    localparam logic [4:0]  LINE_LEN_SAT      = 5'd18;
    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1024;

    typedef enum logic [1:0] {
        HDR_LOW     = 2'd0,
        HDR_HIGH    = 2'd1,
        HDR_PAYLOAD = 2'd2
    } hdr_stage_t;

    // Expected character of the mode-switch line at a given position.
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "B";
            4'd1:    ch = "I";
            4'd2:    ch = "N";
            4'd3:    ch = "A";
            4'd4:    ch = "R";
            4'd5:    ch = "Y";
            4'd6:    ch = "M";
            4'd7:    ch = "O";
            4'd8:    ch = "D";
            4'd9:    ch = "E";
            4'd10:   ch = "-";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/text_then_length_prefixed_deframer.sv
// Byte-stream deframer: text lines first, then length-prefixed binary frames.
// Depends on ttlp_pkg.
//
// Takes one word (a byte plus its chunk-end flag) per clock and cuts the stream
// into packets. In text mode LF is dropped and CR closes a line; a 17-byte line
// starting "BINARYMODE-" switches to binary mode for good, where each frame is a
// little-endian 16-bit length followed by its payload. A length above
// max_frame_len reports frame_too_long and drops the rest of the chunk. Each
// word is decided in the cycle it is accepted and its result, if any, lands in
// the output register in the following cycle, so the block sustains one word per clock.
// s_ready is low only while a held result is not being taken (m_valid high,
// m_ready low). cfg_wr_en writes max_frame_len at once; write it only when idle.
module text_then_length_prefixed_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_chunk_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_packet_end,
    output logic        m_packet_binary,
    output logic        m_mode_switched,
    output logic        m_frame_too_long,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import ttlp_pkg::*;

    logic [15:0] max_frame_len_reg;
    logic        binary_mode_reg,    binary_mode_next;
    logic [4:0]  line_length_reg,    line_length_next;
    logic        prefix_matches_reg, prefix_matches_next;
    logic        drop_next_lf_reg,   drop_next_lf_next;
    hdr_stage_t  hdr_stage_reg,      hdr_stage_next;
    logic [7:0]  length_low_reg,     length_low_next;
    logic [15:0] payload_left_reg,   payload_left_next;
    logic        discarding_reg,     discarding_next;

    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg, packet_end_reg, packet_binary_reg;
    logic        mode_switched_reg, frame_too_long_reg;

    logic        accept;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_byte_valid, res_end, res_binary, res_switched, res_too_long;
    logic        switch_line;
    logic [15:0] frame_len;
    logic [15:0] left_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign switch_line = (line_length_reg == SWITCH_LINE_LEN) && prefix_matches_reg;
    assign frame_len   = {s_data_byte, length_low_reg};
    assign left_dec    = (payload_left_reg != 16'd0) ? payload_left_reg - 16'd1 : 16'd0;

    always_comb begin
        binary_mode_next    = binary_mode_reg;
        line_length_next    = line_length_reg;
        prefix_matches_next = prefix_matches_reg;
        drop_next_lf_next   = drop_next_lf_reg;
        hdr_stage_next      = hdr_stage_reg;
        length_low_next     = length_low_reg;
        payload_left_next   = payload_left_reg;
        discarding_next     = discarding_reg;
        res_valid      = 1'b0;
        res_byte       = 8'h00;
        res_byte_valid = 1'b0;
        res_end        = 1'b0;
        res_binary     = 1'b0;
        res_switched   = 1'b0;
        res_too_long   = 1'b0;

        if (accept) begin
            if (!binary_mode_reg) begin
                if (s_data_byte == LF_BYTE) begin
                    // drop
                end else if (s_data_byte == CR_BYTE) begin
                    line_length_next    = 5'd0;
                    prefix_matches_next = 1'b1;
                    if (switch_line) begin
                        binary_mode_next  = 1'b1;
                        drop_next_lf_next = !s_chunk_end;
                        hdr_stage_next    = HDR_LOW;
                        discarding_next   = 1'b0;
                    end
                    res_valid    = 1'b1;
                    res_end      = 1'b1;
                    res_switched = switch_line;
                end else begin
                    if (line_length_reg < PREFIX_LEN &&
                        s_data_byte != prefix_char(line_length_reg[3:0])) begin
                        prefix_matches_next = 1'b0;
                    end
                    if (line_length_reg < LINE_LEN_SAT) begin
                        line_length_next = line_length_reg + 5'd1;
                    end
                    res_valid      = 1'b1;
                    res_byte       = s_data_byte;
                    res_byte_valid = 1'b1;
                end
            end else if (drop_next_lf_reg && s_data_byte == LF_BYTE) begin
                drop_next_lf_next = 1'b0;
            end else begin
                drop_next_lf_next = 1'b0;
                if (discarding_reg) begin
                    if (s_chunk_end) begin
                        discarding_next = 1'b0;
                    end
                end else begin
                    unique case (hdr_stage_reg)
                        HDR_LOW: begin
                            length_low_next = s_data_byte;
                            hdr_stage_next  = HDR_HIGH;
                        end
                        HDR_HIGH: begin
                            hdr_stage_next = HDR_LOW;
                            if (frame_len > max_frame_len_reg) begin
                                discarding_next = !s_chunk_end;
                                res_valid    = 1'b1;
                                res_binary   = 1'b1;
                                res_too_long = 1'b1;
                            end else if (frame_len == 16'd0) begin
                                res_valid  = 1'b1;
                                res_end    = 1'b1;
                                res_binary = 1'b1;
                            end else begin
                                payload_left_next = frame_len;
                                hdr_stage_next    = HDR_PAYLOAD;
                            end
                        end
                        HDR_PAYLOAD: begin
                            payload_left_next = left_dec;
                            if (left_dec == 16'd0) begin
                                hdr_stage_next = HDR_LOW;
                                res_end        = 1'b1;
                            end
                            res_valid      = 1'b1;
                            res_byte       = s_data_byte;
                            res_byte_valid = 1'b1;
                            res_binary     = 1'b1;
                        end
                        default: begin
                            hdr_stage_next = HDR_LOW;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg  <= MAX_FRAME_LEN_RST;
            binary_mode_reg    <= 1'b0;
            line_length_reg    <= 5'd0;
            prefix_matches_reg <= 1'b1;
            drop_next_lf_reg   <= 1'b0;
            hdr_stage_reg      <= HDR_LOW;
            length_low_reg     <= 8'h00;
            payload_left_reg   <= 16'd0;
            discarding_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_frame_len_reg <= cfg_wr_data;
            end
            binary_mode_reg    <= binary_mode_next;
            line_length_reg    <= line_length_next;
            prefix_matches_reg <= prefix_matches_next;
            drop_next_lf_reg   <= drop_next_lf_next;
            hdr_stage_reg      <= hdr_stage_next;
            length_low_reg     <= length_low_next;
            payload_left_reg   <= payload_left_next;
            discarding_reg     <= discarding_next;
            if (s_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    // Load the result word whenever the output slot is free or being emptied.
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            out_byte_reg       <= res_byte;
            byte_valid_reg     <= res_byte_valid;
            packet_end_reg     <= res_end;
            packet_binary_reg  <= res_binary;
            mode_switched_reg  <= res_switched;
            frame_too_long_reg <= res_too_long;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_byte_valid     = byte_valid_reg;
    assign m_packet_end     = packet_end_reg;
    assign m_packet_binary  = packet_binary_reg;
    assign m_mode_switched  = mode_switched_reg;
    assign m_frame_too_long = frame_too_long_reg;

    a_too_long_is_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_too_long |-> m_packet_binary && !m_byte_valid && !m_packet_end)
        else $error("frame_too_long word carries data or end marker");

    a_switch_sets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode_switched |-> binary_mode_reg && m_packet_end)
        else $error("mode switch word without binary mode");

    a_mode_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        binary_mode_reg |=> binary_mode_reg)
        else $error("binary mode cleared");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_stage_reg == HDR_PAYLOAD |-> payload_left_reg != 16'd0)
        else $error("payload stage with nothing left");

    a_discard_in_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg || drop_next_lf_reg |-> binary_mode_reg)
        else $error("binary-only state set in text mode");

endmodule
